### hw/rtl/vtp_pkg.sv
`timescale 1ns / 1ps

package vtp_pkg;

    localparam int AXES      = 3;
    localparam int COORD_W   = 16;
    localparam int COEF_W    = 21;
    localparam int PROJ_W    = 32;
    localparam int ROW_W     = AXES * COEF_W;
    localparam int REG_W     = 2 * PROJ_W;
    localparam int IDX_W     = 3;

    localparam logic [IDX_W-1:0] REG_ROW_X       = 3'd0;
    localparam logic [IDX_W-1:0] REG_ROW_Y       = 3'd1;
    localparam logic [IDX_W-1:0] REG_ROW_Z       = 3'd2;
    localparam logic [IDX_W-1:0] REG_TRANSLATION = 3'd3;
    localparam logic [IDX_W-1:0] REG_PROJ_XY     = 3'd4;
    localparam logic [IDX_W-1:0] REG_PROJ_Z      = 3'd5;

    // View transform arithmetic.
    localparam int PROD_W      = COEF_W + COORD_W;
    localparam int TRANS_SHIFT = 13;
    localparam int TERM_W      = COEF_W + TRANS_SHIFT;
    localparam int ACC_W       = 40;
    localparam int VIEW_SHIFT  = 10;
    localparam int VIEW_W      = ACC_W - VIEW_SHIFT;

    // Perspective terms.
    localparam int CLIP_W    = PROJ_W + VIEW_W;
    localparam int CZ_W      = CLIP_W + 1;
    localparam int OFF_SHIFT = 8;
    localparam int OFF_W     = PROJ_W + OFF_SHIFT;

    // Divider: quotients beyond QUO_W bits always saturate the outputs.
    localparam int DVD_W   = CZ_W;
    localparam int DVS_W   = VIEW_W + 2;
    localparam int QUO_W   = 37;
    localparam int DIV_LAT = QUO_W + 1;

    // Screen mapping.
    localparam int SCREEN_W     = 1024;
    localparam int SCREEN_H     = 768;
    localparam int SIZE_MAX     = (SCREEN_W > SCREEN_H) ? SCREEN_W : SCREEN_H;
    localparam int NDC_W        = QUO_W + 2;
    localparam int NDC_BIAS     = 65536;
    localparam int SCREEN_SHIFT = 17;
    localparam int PIX_W        = NDC_W + $clog2(SIZE_MAX + 1) + 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic signed [COORD_W-1:0] SAT_MAX = 16'sh7FFF;
    localparam logic signed [COORD_W-1:0] SAT_MIN = 16'sh8000;

    typedef struct packed {
        logic [AXES-1:0][ROW_W-1:0] rows;
        logic [ROW_W-1:0]           translation;
        logic [REG_W-1:0]           proj_xy;
        logic [REG_W-1:0]           proj_z;
    } vtp_cfg_t;

    typedef struct packed {
        logic signed [CLIP_W-1:0] cx;
        logic signed [CLIP_W-1:0] cy;
        logic signed [CZ_W-1:0]   cz;
        logic signed [VIEW_W-1:0] w;
    } vtp_item_t;

    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic neg_z;
        logic cx_neg;
        logic cy_neg;
        logic cz_neg;
        logic w_zero;
        logic w_pos;
    } vtp_side_t;

    function automatic logic signed [COORD_W-1:0] sat16(input logic signed [63:0] x);
        if (x > 64'sd32767)
        begin
            return SAT_MAX;
        end
        else if (x < -64'sd32768)
        begin
            return SAT_MIN;
        end
        return x[COORD_W-1:0];
    endfunction

endpackage

### hw/rtl/vtp_if.sv
`timescale 1ns / 1ps

interface vtp_vertex_if import vtp_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic signed [COORD_W-1:0] vertex_z;

    modport source (output valid, output vertex_x, output vertex_y, output vertex_z,
                    input ready);
    modport sink (input valid, input vertex_x, input vertex_y, input vertex_z,
                  output ready);
endinterface

interface vtp_result_if import vtp_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] screen_x;
    logic signed [COORD_W-1:0] screen_y;
    logic signed [COORD_W-1:0] depth;
    logic                      in_front;
    logic                      zero_w;

    modport source (output valid, output screen_x, output screen_y, output depth,
                    output in_front, output zero_w, input ready);
    modport sink (input valid, input screen_x, input screen_y, input depth,
                  input in_front, input zero_w, output ready);
endinterface

interface vtp_cfg_if import vtp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [REG_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### hw/rtl/vtp_front.sv
`timescale 1ns / 1ps

module vtp_front import vtp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  vtp_cfg_t  cfg,
    vtp_vertex_if.sink vtx,
    output vtp_item_t item,
    output logic      item_valid,
    input  logic      item_ready
);

    logic [3:0] vld_reg;
    logic       adv;

    logic signed [COORD_W-1:0] vin       [AXES];
    logic signed [COEF_W-1:0]  coef      [AXES][AXES];
    logic signed [PROD_W-1:0]  prod_next [AXES][AXES];
    logic signed [PROD_W-1:0]  prod_reg  [AXES][AXES];
    logic signed [TERM_W-1:0]  term_next [AXES];
    logic signed [TERM_W-1:0]  term_reg  [AXES];
    logic signed [ACC_W-1:0]   acc       [AXES];
    logic signed [VIEW_W-1:0]  view_next [AXES];
    logic signed [VIEW_W-1:0]  view_reg  [AXES];

    logic signed [PROJ_W-1:0] sx, sy, sz, off;
    logic signed [CLIP_W-1:0] cx_reg, cy_reg, szw_reg;
    logic signed [OFF_W-1:0]  off_reg;
    logic signed [VIEW_W-1:0] w_reg;
    vtp_item_t                item_reg;

    assign adv       = !vld_reg[3] || item_ready;
    assign vtx.ready = adv;

    assign vin[0] = vtx.vertex_x;
    assign vin[1] = vtx.vertex_y;
    assign vin[2] = vtx.vertex_z;

    assign sx  = $signed(cfg.proj_xy[PROJ_W-1:0]);
    assign sy  = $signed(cfg.proj_xy[REG_W-1:PROJ_W]);
    assign sz  = $signed(cfg.proj_z[PROJ_W-1:0]);
    assign off = $signed(cfg.proj_z[REG_W-1:PROJ_W]);

    always_comb
    begin
        for (int r = 0; r < AXES; r++)
        begin
            for (int k = 0; k < AXES; k++)
            begin
                coef[r][k]      = $signed(cfg.rows[r][COEF_W*k +: COEF_W]);
                prod_next[r][k] = PROD_W'(coef[r][k]) * PROD_W'(vin[k]);
            end
            term_next[r] = TERM_W'($signed(cfg.translation[COEF_W*r +: COEF_W]))
                           <<< TRANS_SHIFT;
            acc[r] = ACC_W'(prod_reg[r][0]) + ACC_W'(prod_reg[r][1])
                   + ACC_W'(prod_reg[r][2]) + ACC_W'(term_reg[r]);
            // Arithmetic shift gives the floor of the division.
            view_next[r] = VIEW_W'(acc[r] >>> VIEW_SHIFT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[2:0], vtx.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg    <= prod_next;
            term_reg    <= term_next;
            view_reg    <= view_next;
            cx_reg      <= CLIP_W'(sx) * CLIP_W'(view_reg[0]);
            cy_reg      <= CLIP_W'(sy) * CLIP_W'(view_reg[1]);
            szw_reg     <= CLIP_W'(sz) * CLIP_W'(view_reg[2]);
            off_reg     <= OFF_W'(off) <<< OFF_SHIFT;
            w_reg       <= view_reg[2];
            item_reg.cx <= cx_reg;
            item_reg.cy <= cy_reg;
            item_reg.cz <= CZ_W'(szw_reg) + CZ_W'(off_reg);
            item_reg.w  <= w_reg;
        end
    end

    assign item       = item_reg;
    assign item_valid = vld_reg[3];

endmodule

### hw/rtl/vtp_queue.sv
`timescale 1ns / 1ps

module vtp_queue import vtp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  vtp_item_t push_item,
    input  logic      push_valid,
    output logic      push_ready,
    output vtp_item_t pop_item,
    output logic      pop_valid,
    input  logic      pop_ready
);

    vtp_item_t         mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              push, pop;

    assign push_ready = count_reg != (QPTR_W + 1)'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### hw/rtl/vtp_div.sv
`timescale 1ns / 1ps

module vtp_div import vtp_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic [QUO_W-1:0] quotient,
    output logic             overflow
);

    logic [DVS_W-1:0] rem_reg [QUO_W+1];
    logic [QUO_W-1:0] low_reg [QUO_W+1];
    logic [QUO_W-1:0] quo_reg [QUO_W+1];
    logic [DVS_W-1:0] dvs_reg [QUO_W+1];
    logic [QUO_W:0]   ovf_reg;
    logic [DVS_W:0]   trial   [QUO_W];
    logic [QUO_W-1:0] ge;
    logic [DVS_W-1:0] head;

    // Upper dividend bits: if they already reach the divisor, the quotient
    // does not fit and the result is flagged as overflowed.
    assign head = DVS_W'(dividend[DVD_W-1:QUO_W]);

    always_comb
    begin
        for (int s = 0; s < QUO_W; s++)
        begin
            trial[s] = {rem_reg[s], low_reg[s][QUO_W-1]};
            ge[s]    = trial[s] >= {1'b0, dvs_reg[s]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= head;
            low_reg[0] <= dividend[QUO_W-1:0];
            quo_reg[0] <= '0;
            dvs_reg[0] <= divisor;
            ovf_reg[0] <= head >= divisor;
            for (int s = 1; s <= QUO_W; s++)
            begin
                rem_reg[s] <= ge[s-1] ? DVS_W'(trial[s-1] - {1'b0, dvs_reg[s-1]})
                                      : DVS_W'(trial[s-1]);
                low_reg[s] <= low_reg[s-1] << 1;
                quo_reg[s] <= {quo_reg[s-1][QUO_W-2:0], ge[s-1]};
                dvs_reg[s] <= dvs_reg[s-1];
                ovf_reg[s] <= ovf_reg[s-1];
            end
        end
    end

    assign quotient = quo_reg[QUO_W];
    assign overflow = ovf_reg[QUO_W];

endmodule

### hw/rtl/vtp_back.sv
`timescale 1ns / 1ps

module vtp_back import vtp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  vtp_item_t item,
    input  logic      item_valid,
    output logic      item_ready,
    vtp_result_if.source res
);

    logic adv;

    logic [CLIP_W-1:0] abs_cx, abs_cy;
    logic [CZ_W-1:0]   abs_cz;
    logic [VIEW_W-1:0] abs_w;
    logic              w_neg;
    vtp_side_t         side_next;

    logic [DVD_W-1:0] mag_x_reg, mag_y_reg, mag_z_reg;
    logic [DVS_W-1:0] dvs_xy_reg, dvs_z_reg;
    vtp_side_t        side_pipe_reg [DIV_LAT+1];
    logic [DIV_LAT:0] vld_pipe_reg;

    logic [QUO_W-1:0] qx, qy, qz, qx_eff, qy_eff, qz_eff;
    logic             ox, oy, oz;
    vtp_side_t        div_side;

    logic signed [NDC_W-1:0] mx, my, mz, ndc_x, ndc_y, ndc_z;
    logic signed [PIX_W-1:0] px_reg, py_reg;
    logic signed [NDC_W-1:0] dz_reg;
    vtp_side_t               m_side_reg;
    logic                    m_vld_reg;

    logic signed [COORD_W-1:0] sx_next, sy_next, dz_next;
    logic signed [COORD_W-1:0] screen_x_reg, screen_y_reg, depth_reg;
    logic                      in_front_reg, zero_w_reg, out_vld_reg;

    assign adv        = !out_vld_reg || res.ready;
    assign item_ready = adv;

    assign w_neg  = item.w[VIEW_W-1];
    assign abs_cx = item.cx[CLIP_W-1] ? CLIP_W'(-item.cx) : CLIP_W'(item.cx);
    assign abs_cy = item.cy[CLIP_W-1] ? CLIP_W'(-item.cy) : CLIP_W'(item.cy);
    assign abs_cz = item.cz[CZ_W-1] ? CZ_W'(-item.cz) : CZ_W'(item.cz);
    assign abs_w  = w_neg ? VIEW_W'(-item.w) : VIEW_W'(item.w);

    always_comb
    begin
        side_next.cx_neg = item.cx[CLIP_W-1];
        side_next.cy_neg = item.cy[CLIP_W-1];
        side_next.cz_neg = item.cz[CZ_W-1];
        side_next.w_zero = item.w == '0;
        side_next.w_pos  = !w_neg && (item.w != '0);
        side_next.neg_x  = item.cx[CLIP_W-1] ^ w_neg;
        side_next.neg_y  = item.cy[CLIP_W-1] ^ w_neg;
        // The depth sign flip for points in front cancels the sign of w.
        side_next.neg_z  = !item.cz[CZ_W-1] && (item.cz != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_pipe_reg <= '0;
            m_vld_reg    <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else if (adv)
        begin
            vld_pipe_reg <= {vld_pipe_reg[DIV_LAT-1:0], item_valid};
            m_vld_reg    <= vld_pipe_reg[DIV_LAT];
            out_vld_reg  <= m_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag_x_reg        <= DVD_W'(abs_cx);
            mag_y_reg        <= DVD_W'(abs_cy);
            mag_z_reg        <= DVD_W'(abs_cz);
            dvs_xy_reg       <= DVS_W'(abs_w);
            dvs_z_reg        <= {abs_w, 2'b00};
            side_pipe_reg[0] <= side_next;
            for (int k = 1; k <= DIV_LAT; k++)
            begin
                side_pipe_reg[k] <= side_pipe_reg[k-1];
            end
        end
    end

    vtp_div u_div_x
    (
        .clk      (clk),
        .en       (adv),
        .dividend (mag_x_reg),
        .divisor  (dvs_xy_reg),
        .quotient (qx),
        .overflow (ox)
    );

    vtp_div u_div_y
    (
        .clk      (clk),
        .en       (adv),
        .dividend (mag_y_reg),
        .divisor  (dvs_xy_reg),
        .quotient (qy),
        .overflow (oy)
    );

    vtp_div u_div_z
    (
        .clk      (clk),
        .en       (adv),
        .dividend (mag_z_reg),
        .divisor  (dvs_z_reg),
        .quotient (qz),
        .overflow (oz)
    );

    // An overflowed quotient is pinned to the largest magnitude, which still
    // saturates every output the same way.
    assign div_side = side_pipe_reg[DIV_LAT];
    assign qx_eff   = ox ? '1 : qx;
    assign qy_eff   = oy ? '1 : qy;
    assign qz_eff   = oz ? '1 : qz;
    assign mx       = NDC_W'(qx_eff);
    assign my       = NDC_W'(qy_eff);
    assign mz       = NDC_W'(qz_eff);
    assign ndc_x    = div_side.neg_x ? -mx : mx;
    assign ndc_y    = div_side.neg_y ? -my : my;
    assign ndc_z    = div_side.neg_z ? -mz : mz;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg     <= PIX_W'(ndc_x + NDC_W'(NDC_BIAS)) * PIX_W'(SCREEN_W);
            py_reg     <= PIX_W'(ndc_y + NDC_W'(NDC_BIAS)) * PIX_W'(SCREEN_H);
            dz_reg     <= ndc_z;
            m_side_reg <= div_side;
        end
    end

    always_comb
    begin
        if (m_side_reg.w_zero)
        begin
            sx_next = m_side_reg.cx_neg ? SAT_MIN : SAT_MAX;
            sy_next = m_side_reg.cy_neg ? SAT_MIN : SAT_MAX;
            dz_next = m_side_reg.cz_neg ? SAT_MIN : SAT_MAX;
        end
        else
        begin
            sx_next = sat16(64'(px_reg >>> SCREEN_SHIFT));
            sy_next = sat16(64'(py_reg >>> SCREEN_SHIFT));
            dz_next = sat16(64'(dz_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            screen_x_reg <= sx_next;
            screen_y_reg <= sy_next;
            depth_reg    <= dz_next;
            in_front_reg <= m_side_reg.w_pos;
            zero_w_reg   <= m_side_reg.w_zero;
        end
    end

    assign res.valid    = out_vld_reg;
    assign res.screen_x = screen_x_reg;
    assign res.screen_y = screen_y_reg;
    assign res.depth    = depth_reg;
    assign res.in_front = in_front_reg;
    assign res.zero_w   = zero_w_reg;

    a_front_not_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.zero_w |-> !res.in_front)
        else $error("in_front set together with zero_w");

    a_zero_w_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.zero_w |->
            (res.screen_x == SAT_MAX || res.screen_x == SAT_MIN) &&
            (res.depth == SAT_MAX || res.depth == SAT_MIN))
        else $error("zero_w result not saturated");

    a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_pipe_reg) && $stable(m_vld_reg))
        else $error("back pipeline moved while stalled");

    a_stall_holds_side: assert property (@(posedge clk) disable iff (!rst_n)
        !adv && m_vld_reg |=> $stable(m_side_reg))
        else $error("sideband changed while stalled");

endmodule

### hw/rtl/vertex_transform_project_unit.sv
`timescale 1ns / 1ps

// Vertex transform and perspective projection. One vertex transaction is
// accepted per clock and one result transaction leaves per clock while the
// result channel keeps accepting; a vertex passes the front pipeline, the
// four-entry queue and the back pipeline, whose depth is set by the three
// restoring dividers that resolve one quotient bit per stage over 37 stages. Configuration
// registers are written through the cfg channel, which is always ready, and
// must only be written while no vertex is in flight.
module vertex_transform_project_unit import vtp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    vtp_vertex_if.sink   vtx,
    vtp_cfg_if.sink      cfg,
    vtp_result_if.source res
);

    vtp_cfg_t  cfg_reg;
    vtp_item_t front_item, queue_item;
    logic      front_valid, front_ready, queue_valid, queue_ready;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_ROW_X:       cfg_reg.rows[0]     <= cfg.data[ROW_W-1:0];
                REG_ROW_Y:       cfg_reg.rows[1]     <= cfg.data[ROW_W-1:0];
                REG_ROW_Z:       cfg_reg.rows[2]     <= cfg.data[ROW_W-1:0];
                REG_TRANSLATION: cfg_reg.translation <= cfg.data[ROW_W-1:0];
                REG_PROJ_XY:     cfg_reg.proj_xy     <= cfg.data;
                REG_PROJ_Z:      cfg_reg.proj_z      <= cfg.data;
                default:         ;
            endcase
        end
    end

    vtp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .vtx        (vtx),
        .item       (front_item),
        .item_valid (front_valid),
        .item_ready (front_ready)
    );

    vtp_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_item  (front_item),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_item   (queue_item),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready)
    );

    vtp_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (queue_item),
        .item_valid (queue_valid),
        .item_ready (queue_ready),
        .res        (res)
    );

endmodule

### bench/vtp_tb_if.sv
`timescale 1ns / 1ps

// The channel interfaces come with the RTL (vtp_if.sv); this file only keeps
// the transaction type that the bench passes between its processes.
package vtp_tb_pkg;
    import vtp_pkg::*;

    typedef struct packed {
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [COORD_W-1:0] depth;
        logic                      in_front;
        logic                      zero_w;
    } screen_point_t;
endpackage

### bench/vertex_transform_project_unit_tb.sv
`timescale 1ns / 1ps

module vertex_transform_project_unit_tb;
    import vtp_pkg::*;
    import vtp_tb_pkg::*;

    localparam int LIMIT = 2000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #1 clk = ~clk;

    vtp_vertex_if vtx();
    vtp_cfg_if    cfg();
    vtp_result_if res();

    vertex_transform_project_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .vtx(vtx.sink),
        .cfg(cfg.sink),
        .res(res.source)
    );

    // Shadow copy of the register file.
    logic [REG_W-1:0] shadow_regs [0:5];

    logic [3*COORD_W-1:0] vertex_q [$];
    screen_point_t        point_q [$];
    int                   errors = 0;
    int                   cycles = 0;
    int                   send_gap = 0;
    int                   recv_gap = 0;
    logic                 hold_gaps = 1'b0;

    // Config channel is driven by the initial block only when idle.
    logic             cfg_valid = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [REG_W-1:0] cfg_data = '0;

    assign cfg.valid = cfg_valid;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    function automatic longint coef(input logic [REG_W-1:0] r, input int k);
        logic signed [COEF_W-1:0] f;
        f = r[COEF_W*k +: COEF_W];
        return longint'(f);
    endfunction

    function automatic longint proj(input logic [REG_W-1:0] r, input int k);
        logic signed [PROJ_W-1:0] f;
        f = r[PROJ_W*k +: PROJ_W];
        return longint'(f);
    endfunction

    // Floor division by a power of two; >>> on a signed value floors.
    function automatic longint floor_shift(input longint x, input int s);
        return x >>> s;
    endfunction

    function automatic logic signed [15:0] clamp16(input longint x);
        if (x > 32767)
        begin
            return 16'sh7FFF;
        end
        if (x < -32768)
        begin
            return 16'sh8000;
        end
        return x[15:0];
    endfunction

    function automatic longint view_axis(input int axis, input longint v [3]);
        longint acc;
        acc = coef(shadow_regs[axis], 0) * v[0] + coef(shadow_regs[axis], 1) * v[1]
            + coef(shadow_regs[axis], 2) * v[2] + coef(shadow_regs[3], axis) * 8192;
        return floor_shift(acc, 10);
    endfunction

    function automatic logic signed [15:0] pixel(input longint c, input longint w,
                                                 input longint size);
        longint ndc;
        longint lim;
        lim = longint'(1) << 45;
        ndc = c / w;
        if (ndc > lim)
        begin
            ndc = lim;
        end
        if (ndc < -lim)
        begin
            ndc = -lim;
        end
        return clamp16(floor_shift((ndc + 65536) * size, 17));
    endfunction

    function automatic screen_point_t project_vertex(input logic [3*COORD_W-1:0] vin);
        longint v [3];
        longint vx, vy, w, cx, cy, cz, d;
        screen_point_t p;
        for (int i = 0; i < 3; i++)
        begin
            v[i] = longint'($signed(vin[COORD_W*i +: COORD_W]));
        end
        vx = view_axis(0, v);
        vy = view_axis(1, v);
        w  = view_axis(2, v);
        cx = proj(shadow_regs[4], 0) * vx;
        cy = proj(shadow_regs[4], 1) * vy;
        cz = proj(shadow_regs[5], 0) * w + proj(shadow_regs[5], 1) * 256;
        if (w == 0)
        begin
            p.sx = (cx >= 0) ? SAT_MAX : SAT_MIN;
            p.sy = (cy >= 0) ? SAT_MAX : SAT_MIN;
            p.depth = (cz >= 0) ? SAT_MAX : SAT_MIN;
            p.in_front = 1'b0;
            p.zero_w = 1'b1;
            return p;
        end
        p.sx = pixel(cx, w, SCREEN_W);
        p.sy = pixel(cy, w, SCREEN_H);
        d = cz / (w * 4);
        if (w > 0)
        begin
            d = -d;
        end
        p.depth = clamp16(d);
        p.in_front = (w > 0);
        p.zero_w = 1'b0;
        return p;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    task automatic add_vertex(input logic [3*COORD_W-1:0] v);
        vertex_q = {vertex_q, v};
    endtask

    // Driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vtx.valid <= 1'b0;
            vtx.vertex_x <= '0;
            vtx.vertex_y <= '0;
            vtx.vertex_z <= '0;
            send_gap <= 0;
        end
        else if (vtx.valid && !vtx.ready)
        begin
        end
        else
        begin
            if (vtx.valid)
            begin
                point_q = {point_q,
                           project_vertex({vtx.vertex_z, vtx.vertex_y, vtx.vertex_x})};
            end
            if (send_gap > 0)
            begin
                vtx.valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (vertex_q.size() > 0)
            begin
                logic [3*COORD_W-1:0] nxt;
                nxt = vertex_q.pop_front();
                vtx.valid <= 1'b1;
                {vtx.vertex_z, vtx.vertex_y, vtx.vertex_x} <= nxt;
                send_gap <= hold_gaps ? 0 : $urandom_range(0, 18);
            end
            else
            begin
                vtx.valid <= 1'b0;
            end
        end
    end

    // Monitor.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res.ready <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            cycles <= cycles + 1;
            if (res.valid && res.ready)
            begin
                if (point_q.size() == 0)
                begin
                    report("unexpected transaction", 0, 0);
                end
                else
                begin
                    screen_point_t e;
                    e = point_q.pop_front();
                    if (res.screen_x !== e.sx)
                        report("screen_x", res.screen_x, e.sx);
                    if (res.screen_y !== e.sy)
                        report("screen_y", res.screen_y, e.sy);
                    if (res.depth !== e.depth)
                        report("depth", res.depth, e.depth);
                    if (res.in_front !== e.in_front)
                        report("in_front", res.in_front, e.in_front);
                    if (res.zero_w !== e.zero_w)
                        report("zero_w", res.zero_w, e.zero_w);
                end
            end
            if (recv_gap > 0)
            begin
                res.ready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end
            else
            begin
                res.ready <= 1'b1;
                if (!hold_gaps && res.valid && res.ready)
                begin
                    recv_gap <= $urandom_range(0, 18);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycles > LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_reg(input int idx, input logic [REG_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx[IDX_W-1:0];
        cfg_data <= val;
        do
        begin
            @(posedge clk);
        end
        while (!cfg.ready);
        cfg_valid <= 1'b0;
        if (idx < 6)
        begin
            shadow_regs[idx] = val;
        end
    endtask

    task automatic drain();
        wait (vertex_q.size() == 0);
        @(posedge clk);
        while (vtx.valid || point_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (60) @(posedge clk);
    endtask

    function automatic logic [ROW_W-1:0] pack3(input int a, input int b, input int c);
        logic [COEF_W-1:0] fa, fb, fc;
        fa = COEF_W'(a);
        fb = COEF_W'(b);
        fc = COEF_W'(c);
        return {fc, fb, fa};
    endfunction

    function automatic logic [3*COORD_W-1:0] rnd_vertex(input int span);
        logic [3*COORD_W-1:0] v;
        for (int i = 0; i < 3; i++)
        begin
            v[COORD_W*i +: COORD_W] = (span == 0) ? 16'($urandom)
                                       : 16'($urandom_range(0, 2 * span) - span);
        end
        return v;
    endfunction

    function automatic logic [REG_W-1:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    // Plausible camera: identity-ish rows, translation moves z forward or back by tz_sign.
    task automatic camera(input int tz_sign);
        write_reg(REG_ROW_X, pack3(1024 + $urandom_range(0, 400) - 200,
                                   $urandom_range(0, 200) - 100, 0));
        write_reg(REG_ROW_Y, pack3(0, 1024 + $urandom_range(0, 400) - 200,
                                   $urandom_range(0, 200) - 100));
        write_reg(REG_ROW_Z, pack3($urandom_range(0, 200) - 100, 0, 1024));
        write_reg(REG_TRANSLATION, pack3($urandom_range(0, 4000) - 2000,
                                         $urandom_range(0, 4000) - 2000,
                                         tz_sign * $urandom_range(200, 30000)));
        write_reg(REG_PROJ_XY, {32'($urandom_range(30000, 150000)),
                                32'($urandom_range(30000, 150000))});
        write_reg(REG_PROJ_Z, {32'(-$urandom_range(0, 200000)),
                               32'($urandom_range(30000, 150000))});
    endtask

    initial
    begin
        for (int i = 0; i < 6; i++)
        begin
            shadow_regs[i] = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Reset registers: every vertex sees w = 0.
        add_vertex({16'sh7FFF, 16'sh8000, 16'sh0000});
        drain();

        // Extremes of the registers, and the unknown indices.
        write_reg(REG_ROW_X, {1'b0, 21'h0FFFFF, 21'h100000, 21'h0FFFFF});
        write_reg(REG_ROW_Y, {1'b0, 21'h100000, 21'h0FFFFF, 21'h100000});
        write_reg(REG_ROW_Z, {1'b0, 21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF});
        write_reg(REG_TRANSLATION, {1'b0, 21'h100000, 21'h0FFFFF, 21'h100000});
        write_reg(REG_PROJ_XY, {32'h80000000, 32'h7FFFFFFF});
        write_reg(REG_PROJ_Z, {32'h7FFFFFFF, 32'h80000000});
        write_reg(6, '1);
        write_reg(7, '1);
        add_vertex({16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
        add_vertex({16'sh8000, 16'sh8000, 16'sh8000});
        add_vertex({16'sh0000, 16'sh0000, 16'sh0000});
        add_vertex({16'sh0001, 16'shFFFF, 16'sh7FFF});
        add_vertex({16'shFFFF, 16'sh0001, 16'sh8000});
        drain();

        // Camera with points behind and in front, plus a z row that cancels
        // to exactly w = 0 for chosen vertices.
        camera(1);
        add_vertex({16'sh0000, 16'sh0000, 16'sh0000});
        add_vertex({16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
        add_vertex({16'sh8000, 16'sh8000, 16'sh8000});
        drain();
        write_reg(REG_TRANSLATION, pack3(100, -100, 0));
        write_reg(REG_ROW_Z, pack3(0, 0, 1024));
        write_reg(REG_PROJ_Z, {32'h00000000, 32'h00010000});
        add_vertex({16'sh0000, 16'sh1234, 16'sh8000});
        add_vertex({16'sh0000, 16'shC000, 16'sh7FFF});
        add_vertex({16'sh0100, 16'sh0000, 16'sh0000});
        add_vertex({16'shFF00, 16'sh0000, 16'sh0000});
        drain();

        // Random phases: mostly realistic cameras, some fully random registers.
        for (int ph = 0; ph < 10; ph++)
        begin
            if (ph % 4 == 3)
            begin
                for (int r = 0; r < 6; r++)
                begin
                    write_reg(r, rnd64());
                end
            end
            else
            begin
                camera((ph % 3 == 1) ? -1 : 1);
            end
            hold_gaps = (ph == 5);
            for (int n = 0; n < 200; n++)
            begin
                add_vertex(rnd_vertex(($urandom_range(0, 3) == 0) ? 0 : 2000));
            end
            // Drain here keeps the sender idle until all results are in.
            drain();
        end

        if (errors == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
